// ----- rtl/lcr_pkg.sv -----
package lcr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_PASSES = 4;
	localparam int PASS_BITS = 3;

	localparam logic [3:0] CODE_LEFT = 4'd1;
	localparam logic [3:0] CODE_RIGHT = 4'd2;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_TOP = 4'd8;

	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT = 2'd2;
	localparam logic [1:0] REG_TOP = 2'd3;

	typedef struct packed {
		logic load;
		logic decide;
		logic mul;
		logic div_start;
		logic update;
	} lcr_cmd_t;

	typedef struct packed {
		logic trivial_acc;
		logic trivial_rej;
		logic div_done;
	} lcr_sts_t;

endpackage

// ----- rtl/lcr_if.sv -----
interface lcr_seg_if #(
	parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lcr_res_if #(
	parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic accepted;
	logic signed [COORD_BITS-1:0] clipped_start_x;
	logic signed [COORD_BITS-1:0] clipped_start_y;
	logic signed [COORD_BITS-1:0] clipped_end_x;
	logic signed [COORD_BITS-1:0] clipped_end_y;
	modport source (output valid, accepted, clipped_start_x, clipped_start_y,
		clipped_end_x, clipped_end_y, input ready);
	modport sink (input valid, accepted, clipped_start_x, clipped_start_y,
		clipped_end_x, clipped_end_y, output ready);
endinterface

interface lcr_cfg_if #(
	parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic [1:0] index;
	logic signed [COORD_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lcr_divider.sv -----
module lcr_divider #(
	parameter int NUM_BITS = 34,
	parameter int DEN_BITS = 17
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_BITS-1:0] num,
	input logic [DEN_BITS-1:0] den,
	output logic done,
	output logic [NUM_BITS-1:0] quo
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [DEN_BITS:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
	assign ge = rem_sh >= {1'b0, den_q};
	assign quo = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			num_q <= {num_q[NUM_BITS-2:0], ge};
		end
	end
endmodule

// ----- rtl/lcr_datapath.sv -----
module lcr_datapath #(
	parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input lcr_pkg::lcr_cmd_t cmd,
	output lcr_pkg::lcr_sts_t sts,
	input logic signed [COORD_BITS-1:0] in_sx,
	input logic signed [COORD_BITS-1:0] in_sy,
	input logic signed [COORD_BITS-1:0] in_ex,
	input logic signed [COORD_BITS-1:0] in_ey,
	input logic signed [COORD_BITS-1:0] left_e,
	input logic signed [COORD_BITS-1:0] bottom_e,
	input logic signed [COORD_BITS-1:0] right_e,
	input logic signed [COORD_BITS-1:0] top_e,
	output logic signed [COORD_BITS-1:0] sx,
	output logic signed [COORD_BITS-1:0] sy,
	output logic signed [COORD_BITS-1:0] ex,
	output logic signed [COORD_BITS-1:0] ey
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [3:0] c1, c2, co;
	logic first_q, neg_q;
	logic signed [DW-1:0] a_q, b_q, c_q;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] quo;
	logic signed [PW:0] q_s;
	logic signed [COORD_BITS-1:0] edge_q;
	logic signed [COORD_BITS-1:0] ox_q, oy_q;
	logic along_y_q;
	logic signed [DW-1:0] bsel, base_a, base_b;
	logic signed [COORD_BITS-1:0] nbase, nv;
	logic signed [COORD_BITS-1:0] px, py;
	logic [DW-1:0] ua, ub, uc;
	logic [2*DW-1:0] umul;

	function automatic logic [3:0] region(input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y, input logic signed [COORD_BITS-1:0] l,
			input logic signed [COORD_BITS-1:0] r, input logic signed [COORD_BITS-1:0] b,
			input logic signed [COORD_BITS-1:0] t);
		logic [3:0] c;
		c = '0;
		if (x < l) c = c | lcr_pkg::CODE_LEFT;
		else if (x > r) c = c | lcr_pkg::CODE_RIGHT;
		if (y < b) c = c | lcr_pkg::CODE_BOTTOM;
		else if (y > t) c = c | lcr_pkg::CODE_TOP;
		return c;
	endfunction

	assign c1 = region(sx_q, sy_q, left_e, right_e, bottom_e, top_e);
	assign c2 = region(ex_q, ey_q, left_e, right_e, bottom_e, top_e);
	assign sts.trivial_acc = (c1 == 4'd0) && (c2 == 4'd0);
	assign sts.trivial_rej = (c1 & c2) != 4'd0;
	assign co = (c1 != 4'd0) ? c1 : c2;

	assign ua = a_q[DW-1] ? DW'(-a_q) : DW'(a_q);
	assign ub = b_q[DW-1] ? DW'(-b_q) : DW'(b_q);
	assign uc = c_q[DW-1] ? DW'(-c_q) : DW'(c_q);
	assign umul = ua * ub;

	lcr_divider #(.NUM_BITS(PW), .DEN_BITS(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(prod_q), .den(uc), .done(sts.div_done), .quo(quo)
	);

	assign q_s = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign nbase = along_y_q ? oy_q : ox_q;
	assign nv = COORD_BITS'(nbase + q_s[COORD_BITS-1:0]);
	assign px = along_y_q ? edge_q : nv;
	assign py = along_y_q ? nv : edge_q;

	assign bsel = '0;
	assign base_a = bsel;
	assign base_b = base_a;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= in_sx; sy_q <= in_sy; ex_q <= in_ex; ey_q <= in_ey;
		end else if (cmd.decide) begin
			first_q <= c1 != 4'd0;
			ox_q <= sx_q;
			oy_q <= sy_q;
			if ((co & lcr_pkg::CODE_TOP) != 4'd0 || (co & lcr_pkg::CODE_BOTTOM) != 4'd0) begin
				edge_q <= ((co & lcr_pkg::CODE_TOP) != 4'd0) ? top_e : bottom_e;
				along_y_q <= 1'b0;
				a_q <= DW'(ex_q) - DW'(sx_q);
				b_q <= (((co & lcr_pkg::CODE_TOP) != 4'd0) ? DW'(top_e) : DW'(bottom_e))
					- DW'(sy_q) + base_b;
				c_q <= DW'(ey_q) - DW'(sy_q);
			end else begin
				edge_q <= ((co & lcr_pkg::CODE_RIGHT) != 4'd0) ? right_e : left_e;
				along_y_q <= 1'b1;
				a_q <= DW'(ey_q) - DW'(sy_q);
				b_q <= (((co & lcr_pkg::CODE_RIGHT) != 4'd0) ? DW'(right_e) : DW'(left_e))
					- DW'(sx_q);
				c_q <= DW'(ex_q) - DW'(sx_q);
			end
		end else if (cmd.mul) begin
			prod_q <= umul;
			neg_q <= (a_q[DW-1] ^ b_q[DW-1] ^ c_q[DW-1]) && (umul != '0);
		end else if (cmd.update) begin
			if (first_q) begin
				sx_q <= px; sy_q <= py;
			end else begin
				ex_q <= px; ey_q <= py;
			end
		end
	end

	assign sx = sx_q;
	assign sy = sy_q;
	assign ex = ex_q;
	assign ey = ey_q;
endmodule

// ----- rtl/lcr_ctrl.sv -----
module lcr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_load,
	output logic out_acc,
	input logic out_free,
	output lcr_pkg::lcr_cmd_t cmd,
	input lcr_pkg::lcr_sts_t sts
);
	typedef enum logic [2:0] {IDLE, DECIDE, MUL, DIV, WAIT, UPD, FIN} state_t;

	state_t state_q;
	logic [lcr_pkg::PASS_BITS-1:0] pass_q;

	assign in_ready = (state_q == IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.decide = (state_q == DECIDE) && !sts.trivial_acc && !sts.trivial_rej
		&& (pass_q != lcr_pkg::PASS_BITS'(lcr_pkg::MAX_PASSES));
	assign cmd.mul = (state_q == MUL);
	assign cmd.div_start = (state_q == DIV);
	assign cmd.update = (state_q == UPD);
	assign out_load = (state_q == FIN) && out_free;
	assign out_acc = sts.trivial_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pass_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (cmd.load) begin
					state_q <= DECIDE;
					pass_q <= '0;
				end
				DECIDE: state_q <= cmd.decide ? MUL : FIN;
				MUL: state_q <= DIV;
				DIV: state_q <= WAIT;
				WAIT: if (sts.div_done) state_q <= UPD;
				UPD: begin
					pass_q <= pass_q + 1'b1;
					state_q <= DECIDE;
				end
				FIN: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/line_clip_rectangle_top.sv -----
// Channel | Direction | Payload
// cfg     | in        | index (register 0..3), data
// seg     | in        | start_x, start_y, end_x, end_y
// res     | out       | accepted, clipped_start_x/y, clipped_end_x/y
// Each segment takes up to four clipping passes; a pass spends most of its time
// in the bit-serial divider (one quotient bit per cycle, 2*COORD_BITS+2 bits).
// One segment is in work at a time.
// Reset clears the control and loads the rectangle 0, 0, 799, 799.
// A result waits in its output register while the next segment is taken.
module line_clip_rectangle_top #(
	parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	lcr_cfg_if.sink cfg,
	lcr_seg_if.sink seg,
	lcr_res_if.source res
);
	logic signed [COORD_BITS-1:0] left_q, bottom_q, right_q, top_q;
	logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
	lcr_pkg::lcr_cmd_t cmd;
	lcr_pkg::lcr_sts_t sts;
	logic out_load, out_acc, out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			bottom_q <= '0;
			right_q <= COORD_BITS'(799);
			top_q <= COORD_BITS'(799);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lcr_pkg::REG_LEFT: left_q <= cfg.data;
				lcr_pkg::REG_BOTTOM: bottom_q <= cfg.data;
				lcr_pkg::REG_RIGHT: right_q <= cfg.data;
				lcr_pkg::REG_TOP: top_q <= cfg.data;
				default: ;
			endcase
		end
	end

	lcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(seg.valid), .in_ready(seg.ready),
		.out_load(out_load), .out_acc(out_acc), .out_free(out_free),
		.cmd(cmd), .sts(sts)
	);

	lcr_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_sx(seg.start_x), .in_sy(seg.start_y), .in_ex(seg.end_x), .in_ey(seg.end_y),
		.left_e(left_q), .bottom_e(bottom_q), .right_e(right_q), .top_e(top_q),
		.sx(sx), .sy(sy), .ex(ex), .ey(ey)
	);

	assign out_free = !res.valid || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (out_load) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.accepted <= out_acc;
			res.clipped_start_x <= out_acc ? sx : '0;
			res.clipped_start_y <= out_acc ? sy : '0;
			res.clipped_end_x <= out_acc ? ex : '0;
			res.clipped_end_y <= out_acc ? ey : '0;
		end
	end
endmodule

// ----- tb/tb_line_clip_rectangle_checker.sv -----
module tb_line_clip_rectangle_checker (
	input logic clk,
	input logic arst_n,
	lcr_cfg_if.sink cfg,
	lcr_seg_if.sink seg,
	lcr_res_if.sink res,
	output int fail_count,
	output int pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [15:0] coord_t;

	typedef struct packed {
		logic accepted;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} clip_result_t;

	longint rect_left, rect_bottom, rect_right, rect_top;
	clip_result_t clip_queue[$];

	function automatic logic [3:0] outcode(longint x, longint y);
		logic [3:0] c;
		c = 4'd0;
		if (x < rect_left) c |= lcr_pkg::CODE_LEFT;
		else if (x > rect_right) c |= lcr_pkg::CODE_RIGHT;
		if (y < rect_bottom) c |= lcr_pkg::CODE_BOTTOM;
		else if (y > rect_top) c |= lcr_pkg::CODE_TOP;
		return c;
	endfunction

	function automatic longint scaled_quot(longint a, longint b, longint c);
		longint p;
		if (c == 0) return 0;
		p = a * b;
		return p / c;
	endfunction

	function automatic clip_result_t clip_segment(coord_t isx, coord_t isy, coord_t iex,
		coord_t iey);
		longint sx, sy, ex, ey, nx, ny;
		logic [3:0] c1, c2, co;
		logic acc, decided;
		clip_result_t r;
		sx = isx; sy = isy; ex = iex; ey = iey;
		c1 = outcode(sx, sy);
		c2 = outcode(ex, ey);
		acc = 1'b0;
		decided = 1'b0;
		for (int pass = 0; pass < lcr_pkg::MAX_PASSES; pass++) begin
			if (c1 == 0 && c2 == 0) begin
				acc = 1'b1;
				decided = 1'b1;
				break;
			end
			if ((c1 & c2) != 0) begin
				decided = 1'b1;
				break;
			end
			co = (c1 != 0) ? c1 : c2;
			if (co & lcr_pkg::CODE_TOP) begin
				nx = sx + scaled_quot(ex - sx, rect_top - sy, ey - sy);
				ny = rect_top;
			end else if (co & lcr_pkg::CODE_BOTTOM) begin
				nx = sx + scaled_quot(ex - sx, rect_bottom - sy, ey - sy);
				ny = rect_bottom;
			end else if (co & lcr_pkg::CODE_RIGHT) begin
				ny = sy + scaled_quot(ey - sy, rect_right - sx, ex - sx);
				nx = rect_right;
			end else begin
				ny = sy + scaled_quot(ey - sy, rect_left - sx, ex - sx);
				nx = rect_left;
			end
			if (c1 != 0) begin
				sx = nx; sy = ny; c1 = outcode(sx, sy);
			end else begin
				ex = nx; ey = ny; c2 = outcode(ex, ey);
			end
		end
		if (!decided) acc = (c1 == 0 && c2 == 0);
		r = '0;
		r.accepted = acc;
		if (acc) begin
			r.sx = coord_t'(sx);
			r.sy = coord_t'(sy);
			r.ex = coord_t'(ex);
			r.ey = coord_t'(ey);
		end
		return r;
	endfunction

	assign pending_count = clip_queue.size();

	always @(posedge clk or negedge arst_n) begin
		clip_result_t want, got;
		if (!arst_n) begin
			rect_left <= 0;
			rect_bottom <= 0;
			rect_right <= 799;
			rect_top <= 799;
			fail_count <= 0;
			clip_queue.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					lcr_pkg::REG_LEFT: rect_left <= cfg.data;
					lcr_pkg::REG_BOTTOM: rect_bottom <= cfg.data;
					lcr_pkg::REG_RIGHT: rect_right <= cfg.data;
					lcr_pkg::REG_TOP: rect_top <= cfg.data;
				endcase
			end
			if (seg.valid && seg.ready)
				clip_queue.push_back(clip_segment(seg.start_x, seg.start_y, seg.end_x,
					seg.end_y));
			if (res.valid && res.ready) begin
				got = {res.accepted, res.clipped_start_x, res.clipped_start_y,
					res.clipped_end_x, res.clipped_end_y};
				if (clip_queue.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result transfer: %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = clip_queue.pop_front();
					if (want !== got) begin
						if (fail_count < 10)
							$display({"Mismatch: expected acc=%0d (%0d,%0d)-(%0d,%0d)",
								" got acc=%0d (%0d,%0d)-(%0d,%0d)"},
								want.accepted, want.sx, want.sy, want.ex, want.ey,
								got.accepted, got.sx, got.sy, got.ex, got.ey);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/tb_line_clip_rectangle_top.sv -----
module tb_line_clip_rectangle_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_SEGMENTS = 1330;
	localparam int HOLD_CYCLES = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending_count;
	int idle_cycles;
	bit long_hold = 1'b0;
	bit hold_taken = 1'b0;
	int hold_cycles = 0;

	lcr_cfg_if cfg ();
	lcr_seg_if seg ();
	lcr_res_if res ();

	line_clip_rectangle_top i_dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .seg(seg),
		.res(res));

	tb_line_clip_rectangle_checker i_checker (.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.seg(seg), .res(res), .fail_count(fail_count), .pending_count(pending_count));

	always #1 clk = ~clk;

	always @(posedge clk) begin
		int pick;
		pick = $urandom_range(0, 99);
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (long_hold && !hold_taken) begin
			res.ready <= 1'b0;
			hold_taken <= 1'b1;
			hold_cycles <= HOLD_CYCLES - 1;
		end else if (hold_cycles > 0) begin
			res.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			if ((($time / 400) % 3) == 0) res.ready <= 1'b1;
			else res.ready <= (pick < 60);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (seg.valid && seg.ready) || (cfg.valid && cfg.ready) ||
			(res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_edge(logic [1:0] idx, logic signed [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_rectangle(logic signed [15:0] l, logic signed [15:0] b,
		logic signed [15:0] r, logic signed [15:0] t);
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		write_edge(lcr_pkg::REG_LEFT, l);
		write_edge(lcr_pkg::REG_BOTTOM, b);
		write_edge(lcr_pkg::REG_RIGHT, r);
		write_edge(lcr_pkg::REG_TOP, t);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_segment(logic signed [15:0] sx, logic signed [15:0] sy,
		logic signed [15:0] ex, logic signed [15:0] ey);
		seg.valid <= 1'b1;
		seg.start_x <= sx;
		seg.start_y <= sy;
		seg.end_x <= ex;
		seg.end_y <= ey;
		do @(posedge clk); while (!seg.ready);
	endtask

	task automatic pause_sender();
		seg.valid <= 1'b0;
		repeat ($urandom_range(1, 30)) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 1600)) - 400);
			default: return 16'(int'($urandom_range(0, 20)) - 10);
		endcase
	endfunction

	initial begin
		int burst, mode;
		cfg.valid <= 1'b0;
		cfg.index <= lcr_pkg::REG_LEFT;
		cfg.data <= '0;
		seg.valid <= 1'b0;
		seg.start_x <= '0;
		seg.start_y <= '0;
		seg.end_x <= '0;
		seg.end_y <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_segment(100, 100, 200, 200);
		send_segment(-100, 400, 900, 400);
		send_segment(400, -100, 400, 900);
		send_segment(-50, -50, 900, 850);
		send_segment(-100, -100, -50, 900);
		send_segment(900, 900, 1000, 100);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(32767, -32768, -32768, 32767);
		send_segment(-32768, 0, 32767, 0);
		send_segment(0, 799, 799, 0);
		send_segment(-10, 820, 820, -10);
		pause_sender();

		set_rectangle(-32768, -32768, 32767, 32767);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(-1, 0, 5, -5);
		pause_sender();
		set_rectangle(-5, -5, 5, 5);
		send_segment(-32768, 32767, 32767, -32768);
		send_segment(-20, 3, 20, -3);
		send_segment(-7, -20, 9, 30);
		send_segment(-32768, -32768, -32768, 32767);
		pause_sender();
		set_rectangle(5, 5, -5, -5);
		send_segment(0, 0, 1, 1);
		send_segment(-20, -20, 20, 20);
		send_segment(-32768, 32767, 32767, -32768);
		pause_sender();
		set_rectangle(32767, 32767, -32768, -32768);
		send_segment(-3, 4, 7, -9);
		send_segment(32767, 32767, 32767, 32767);
		pause_sender();

		set_rectangle(0, 0, 799, 799);
		long_hold <= 1'b1;
		for (int i = 0; i < 6; i++)
			send_segment(16'($urandom_range(0, 799)), -200,
				16'($urandom_range(0, 799)), 1000);
		seg.valid <= 1'b0;

		for (int n = 0; n < RANDOM_SEGMENTS; ) begin
			if (n % 300 == 0) begin
				seg.valid <= 1'b0;
				case ((n / 300) % 3)
					0: set_rectangle(rand_coord(1), rand_coord(1),
						16'(799 + rand_coord(1)), 16'(799 + rand_coord(1)));
					1: set_rectangle(-16, -16, 16, 16);
					default: set_rectangle(rand_coord(0), rand_coord(0), rand_coord(0),
						rand_coord(0));
				endcase
			end
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				mode = $urandom_range(0, 2);
				send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(mode));
				n++;
			end
			if ($urandom_range(0, 3) != 0) pause_sender();
		end
		seg.valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
